// ===== rtl/bzcq_pkg.sv =====
// ----------------------------------------------------------------------------
// bzcq_pkg
// Types and constants shared by the back-EMF zero-cross qualifier.
// ----------------------------------------------------------------------------
package bzcq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LANE_W     = 4;
  localparam int NUM_LANES  = SAMPLE_W / LANE_W;
  localparam int FILTER_W   = 5;
  localparam int INTERVAL_W = 16;
  localparam int STEP_W     = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_FILTER = 16;

  localparam logic [FILTER_W-1:0]   FILTER_RESET = 5'd5;
  localparam logic [INTERVAL_W-1:0] FAST_RESET   = 16'd400;
  localparam logic [INTERVAL_W-1:0] SLOW_RESET   = 16'd600;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FILT_LEN       = 2'd0,
    REG_FAST_THRESHOLD = 2'd1,
    REG_SLOW_THRESHOLD = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_COMMUTATE = 1'b0,
    OP_EDGE      = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PHASE_C = 2'd0,
    PHASE_A = 2'd1,
    PHASE_B = 2'd2
  } phase_t;

  typedef struct packed {
    logic served;
    logic zero_cross;
    logic clear_rising;
    logic clear_falling;
  } edge_t;

  typedef struct packed {
    logic                  zero_cross;
    logic [1:0]            phase_select;
    logic                  medium_speed;
    logic                  trigger_falling;
    logic                  clear_rising;
    logic                  clear_falling;
    logic [INTERVAL_W-1:0] recorded_interval;
  } result_t;

endpackage

// ===== rtl/bzcq_if.sv =====
// ----------------------------------------------------------------------------
// bzcq_if
// Handshake channels of the zero-cross qualifier: items, results, config.
// ----------------------------------------------------------------------------
interface bzcq_item_if import bzcq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [STEP_W-1:0]     step;
  logic                  expect_rise;
  logic [INTERVAL_W-1:0] mean_interval;
  logic [INTERVAL_W-1:0] elapsed_interval;
  logic                  falling_pending;
  logic                  rising_pending;
  logic [SAMPLE_W-1:0]   samples;

  modport source (
    output valid, op, step, expect_rise, mean_interval, elapsed_interval,
           falling_pending, rising_pending, samples,
    input  ready
  );
  modport sink (
    input  valid, op, step, expect_rise, mean_interval, elapsed_interval,
           falling_pending, rising_pending, samples,
    output ready
  );
endinterface

interface bzcq_result_if import bzcq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  zero_cross;
  logic [1:0]            phase_select;
  logic                  medium_speed;
  logic                  trigger_falling;
  logic                  clear_rising;
  logic                  clear_falling;
  logic [INTERVAL_W-1:0] recorded_interval;

  modport source (
    output valid, zero_cross, phase_select, medium_speed, trigger_falling,
           clear_rising, clear_falling, recorded_interval,
    input  ready
  );
  modport sink (
    input  valid, zero_cross, phase_select, medium_speed, trigger_falling,
           clear_rising, clear_falling, recorded_interval,
    output ready
  );
endinterface

interface bzcq_cfg_if import bzcq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/bzcq_lane.sv =====
// ----------------------------------------------------------------------------
// bzcq_lane
// Checks one slice of comparator reads against the expected level.
// ----------------------------------------------------------------------------
module bzcq_lane import bzcq_pkg::*; #(
  parameter int BASE = 0
) (
  input  logic [LANE_W-1:0]   chunk,
  input  logic                expected,
  input  logic [FILTER_W-1:0] level,
  output logic                hit
);

  logic [LANE_W-1:0] hit_bits;

  always_comb begin
    for (int j = 0; j < LANE_W; j++) begin
      hit_bits[j] = (chunk[j] == expected) && (level > FILTER_W'(BASE + j));
    end
  end

  assign hit = |hit_bits;

endmodule

// ===== rtl/bzcq_merge.sv =====
// ----------------------------------------------------------------------------
// bzcq_merge
// Combines lane hits with the interval test and picks the flag to clear.
// ----------------------------------------------------------------------------
module bzcq_merge import bzcq_pkg::*; (
  input  logic [NUM_LANES-1:0]  hits,
  input  logic                  op,
  input  logic                  falling_pending,
  input  logic                  rising_pending,
  input  logic [INTERVAL_W-1:0] elapsed_interval,
  input  logic [INTERVAL_W-1:0] mean_interval,
  input  logic                  first_read,
  input  logic                  expected,
  output edge_t                 edge_res
);

  logic long_enough;
  logic do_clear;

  always_comb begin
    long_enough = elapsed_interval > {1'b0, mean_interval[INTERVAL_W-1:1]};
    do_clear    = long_enough || (first_read == expected);
    edge_res.served        = (op == OP_EDGE) && (falling_pending || rising_pending);
    edge_res.zero_cross    = edge_res.served && long_enough && !(|hits);
    // falling wins when both are pending
    edge_res.clear_falling = edge_res.served && do_clear && falling_pending;
    edge_res.clear_rising  = edge_res.served && do_clear && !falling_pending;
  end

endmodule

// ===== rtl/bzcq_top_dummy_placeholder.sv =====
// ----------------------------------------------------------------------------
// bzcq_sat
// Saturates a written filter level into the supported range.
// ----------------------------------------------------------------------------
module bzcq_sat import bzcq_pkg::*; (
  input  logic [FILTER_W-1:0] raw,
  output logic [FILTER_W-1:0] level
);

  always_comb begin
    if (raw == '0) begin
      level = FILTER_W'(1);
    end else if ({1'b0, raw} > (FILTER_W + 1)'(MAX_FILTER)) begin
      level = FILTER_W'(MAX_FILTER);
    end else begin
      level = raw;
    end
  end

endmodule

// ===== rtl/bemf_zero_cross_qualifier.sv =====
// ----------------------------------------------------------------------------
// bemf_zero_cross_qualifier
// Qualifies back-EMF zero crossings of a sensorless BLDC motor.
//
// Channels: item (sink) takes commutation words (op 0) and comparator edge
// words (op 1); result (source) returns exactly one word per item; cfg takes
// register writes (0 filter level, 1 fast threshold, 2 slow threshold) and is
// always ready, to be used while no item is in flight.
// A result word is registered in the result stage, or in the skid register
// while the result side stalls. Throughput: one item per cycle while the skid
// register is empty; the sixteen comparator reads are checked by four lanes of
// four reads each in the accept cycle and ORed in the merge. The one-word skid
// register lets the item channel accept one more item after the result side
// stalls; ready then drops until the skid word has moved on.
// Reset: state clears to phase C, high speed, rising trigger, interval 0;
// filter level 5, thresholds 400 and 600; no result is pending.
// ----------------------------------------------------------------------------
module bemf_zero_cross_qualifier import bzcq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  bzcq_cfg_if.sink      cfg,
  bzcq_item_if.sink     item,
  bzcq_result_if.source result
);

  logic [FILTER_W-1:0]   filt_len;
  logic [INTERVAL_W-1:0] fast_threshold;
  logic [INTERVAL_W-1:0] slow_threshold;
  logic [FILTER_W-1:0]   filter_sat;

  logic                  medium_flag, medium_flag_next;
  logic                  exp_level, exp_level_next;
  phase_t                phase_reg, phase_reg_next;
  logic                  falling_trig_reg, falling_trig_reg_next;
  logic [INTERVAL_W-1:0] interval_reg, interval_reg_next;

  logic [NUM_LANES-1:0]  hits;
  edge_t                 edge_res;
  result_t               res_new;
  result_t               out_q;
  result_t               skid_q;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  accept;
  logic                  out_free;

  // configuration
  assign cfg.ready = 1'b1;

  bzcq_sat u_sat (
    .raw   (cfg.data[FILTER_W-1:0]),
    .level (filter_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filt_len       <= FILTER_RESET;
      fast_threshold <= FAST_RESET;
      slow_threshold <= SLOW_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_FILT_LEN:       filt_len       <= filter_sat;
        REG_FAST_THRESHOLD: fast_threshold <= cfg.data;
        REG_SLOW_THRESHOLD: slow_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // sample lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bzcq_lane #(
      .BASE (i * LANE_W)
    ) u_lane (
      .chunk    (item.samples[i*LANE_W +: LANE_W]),
      .expected (exp_level),
      .level    (filt_len),
      .hit      (hits[i])
    );
  end

  bzcq_merge u_merge (
    .hits             (hits),
    .op               (item.op),
    .falling_pending  (item.falling_pending),
    .rising_pending   (item.rising_pending),
    .elapsed_interval (item.elapsed_interval),
    .mean_interval    (item.mean_interval),
    .first_read       (item.samples[0]),
    .expected         (exp_level),
    .edge_res         (edge_res)
  );

  // state update
  always_comb begin
    medium_flag_next      = medium_flag;
    exp_level_next        = exp_level;
    phase_reg_next        = phase_reg;
    falling_trig_reg_next = falling_trig_reg;
    interval_reg_next     = interval_reg;
    if (item.op == OP_COMMUTATE) begin
      exp_level_next        = item.expect_rise;
      falling_trig_reg_next = item.expect_rise;
      // fast test first, then slow test on the updated flag
      medium_flag_next = (medium_flag && !(item.mean_interval < fast_threshold))
                         || (item.mean_interval > slow_threshold);
      case (item.step)
        3'd1, 3'd4: phase_reg_next = PHASE_C;
        3'd2, 3'd5: phase_reg_next = PHASE_A;
        3'd3, 3'd6: phase_reg_next = PHASE_B;
        default:    phase_reg_next = phase_reg;
      endcase
    end else if (edge_res.served) begin
      interval_reg_next = item.elapsed_interval;
    end
  end

  always_comb begin
    res_new.zero_cross        = edge_res.zero_cross;
    res_new.phase_select      = phase_reg_next;
    res_new.medium_speed      = medium_flag_next;
    res_new.trigger_falling   = falling_trig_reg_next;
    res_new.clear_rising      = edge_res.clear_rising;
    res_new.clear_falling     = edge_res.clear_falling;
    res_new.recorded_interval = interval_reg_next;
  end

  assign item.ready = !skid_valid;
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      medium_flag      <= 1'b0;
      exp_level        <= 1'b0;
      phase_reg        <= PHASE_C;
      falling_trig_reg <= 1'b0;
      interval_reg     <= '0;
    end else if (accept) begin
      medium_flag      <= medium_flag_next;
      exp_level        <= exp_level_next;
      phase_reg        <= phase_reg_next;
      falling_trig_reg <= falling_trig_reg_next;
      interval_reg     <= interval_reg_next;
    end
  end

  // result stage and skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_new;
      end
    end else if (accept) begin
      skid_q <= res_new;
    end
  end

  assign result.valid             = out_valid;
  assign result.zero_cross        = out_q.zero_cross;
  assign result.phase_select      = out_q.phase_select;
  assign result.medium_speed      = out_q.medium_speed;
  assign result.trigger_falling   = out_q.trigger_falling;
  assign result.clear_rising      = out_q.clear_rising;
  assign result.clear_falling     = out_q.clear_falling;
  assign result.recorded_interval = out_q.recorded_interval;

  // checks
  a_one_clear: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.clear_rising && result.clear_falling))
    else $error("both edge flags cleared by one word");

  a_cross_clears: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.zero_cross) |-> (result.clear_rising || result.clear_falling))
    else $error("crossing reported without clearing a flag");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while result stage empty");

  a_filter_range: assert property (@(posedge clk) disable iff (rst)
    (filt_len != '0) && ({1'b0, filt_len} <= (FILTER_W + 1)'(MAX_FILTER)))
    else $error("filter level out of range");

endmodule

// ===== sim/bzcq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bzcq_checker
// Watches the config, item and result channels of the zero-cross qualifier.
// Keeps its own copy of the registers and of the commutation and edge state,
// works out the result word for every accepted item and compares each
// accepted result word, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module bzcq_checker import bzcq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  bzcq_cfg_if    cfg,
  bzcq_item_if   item,
  bzcq_result_if result,
  output int     errors,
  output int     pending
);

  logic [FILTER_W-1:0]   filter_q;
  logic [INTERVAL_W-1:0] fast_q;
  logic [INTERVAL_W-1:0] slow_q;
  logic                  medium_q;
  logic                  level_q;
  logic                  trig_q;
  phase_t                phase_q;
  logic [INTERVAL_W-1:0] interval_q;
  result_t               zc_predictions[$];

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic result_t qualify_word(
    op_t                   op,
    logic [STEP_W-1:0]     step,
    logic                  rise,
    logic [INTERVAL_W-1:0] avg,
    logic [INTERVAL_W-1:0] elapsed,
    logic                  fpend,
    logic                  rpend,
    logic [SAMPLE_W-1:0]   samples
  );
    result_t             r;
    logic [SAMPLE_W-1:0] win;
    logic [SAMPLE_W-1:0] hits;
    logic                do_clear;
    r = '0;
    do_clear = 1'b0;
    if (op == OP_COMMUTATE) begin
      level_q = rise;
      // fast test first, then slow test on the updated flag
      if (avg < fast_q && medium_q) begin
        medium_q = 1'b0;
      end
      if (avg > slow_q && !medium_q) begin
        medium_q = 1'b1;
      end
      case (step)
        3'd1, 3'd4: phase_q = PHASE_C;
        3'd2, 3'd5: phase_q = PHASE_A;
        3'd3, 3'd6: phase_q = PHASE_B;
        default: ;
      endcase
      trig_q = rise;
    end else if (fpend || rpend) begin
      interval_q = elapsed;
      if (elapsed > (avg >> 1)) begin
        win = SAMPLE_W'((32'd1 << filter_q) - 32'd1);
        hits = level_q ? (samples & win) : (~samples & win);
        do_clear = 1'b1;
        r.zero_cross = (hits == '0);
      end else if (samples[0] == level_q) begin
        do_clear = 1'b1;
      end
      // falling flag is served first
      r.clear_falling = do_clear && fpend;
      r.clear_rising  = do_clear && !fpend;
    end
    r.phase_select      = phase_q;
    r.medium_speed      = medium_q;
    r.trigger_falling   = trig_q;
    r.recorded_interval = interval_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    logic [FILTER_W-1:0] lvl;
    result_t             want;
    if (rst) begin
      filter_q   = FILTER_RESET;
      fast_q     = FAST_RESET;
      slow_q     = SLOW_RESET;
      medium_q   = 1'b0;
      level_q    = 1'b0;
      trig_q     = 1'b0;
      phase_q    = PHASE_C;
      interval_q = '0;
      zc_predictions.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.addr))
          REG_FILT_LEN: begin
            lvl = cfg.data[FILTER_W-1:0];
            if (lvl == '0) begin
              filter_q = FILTER_W'(1);
            end else if (lvl > MAX_FILTER) begin
              filter_q = FILTER_W'(MAX_FILTER);
            end else begin
              filter_q = lvl;
            end
          end
          REG_FAST_THRESHOLD: fast_q = cfg.data;
          REG_SLOW_THRESHOLD: slow_q = cfg.data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (zc_predictions.size() == 0) begin
          report_mismatch("result word with nothing predicted", 0, 0);
        end else begin
          want = zc_predictions.pop_front();
          check_field("zero_cross", result.zero_cross, want.zero_cross);
          check_field("phase_select", result.phase_select, want.phase_select);
          check_field("medium_speed", result.medium_speed, want.medium_speed);
          check_field("trigger_falling", result.trigger_falling, want.trigger_falling);
          check_field("clear_rising", result.clear_rising, want.clear_rising);
          check_field("clear_falling", result.clear_falling, want.clear_falling);
          check_field("recorded_interval", result.recorded_interval,
                      want.recorded_interval);
        end
      end
      if (item.valid && item.ready) begin
        zc_predictions.push_back(qualify_word(op_t'(item.op), item.step, item.expect_rise,
                                              item.mean_interval, item.elapsed_interval,
                                              item.falling_pending, item.rising_pending,
                                              item.samples));
      end
    end
    pending = zc_predictions.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the back-EMF zero-cross qualifier. Runs a directed set of
// commutation and edge words, then phases of shaped random words under
// several register settings, with random gaps on both sides, a stretch
// without gaps and a long result stall. The checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  import bzcq_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    op_t                   op;
    logic [STEP_W-1:0]     step;
    logic                  rise;
    logic [INTERVAL_W-1:0] avg;
    logic [INTERVAL_W-1:0] elapsed;
    logic                  fpend;
    logic                  rpend;
    logic [SAMPLE_W-1:0]   samples;
  } bemf_word_t;

  logic clk;
  logic rst;
  logic hold_off;
  logic press_req;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   error_count;
  int   words_in_flight;

  int                    shape_filter;
  logic                  shape_level;
  logic [INTERVAL_W-1:0] shape_fast;
  logic [INTERVAL_W-1:0] shape_slow;
  bemf_word_t            word_queue[$];

  bzcq_cfg_if    cfg_ch();
  bzcq_item_if   item_ch();
  bzcq_result_if result_ch();

  bemf_zero_cross_qualifier u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  bzcq_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (error_count),
    .pending (words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // item source: holds a word until taken
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        void'(word_queue.pop_front());
      end
      if (item_ch.valid && !item_ch.ready) begin
      end else if (word_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        item_ch.valid            <= 1'b1;
        item_ch.op               <= word_queue[0].op;
        item_ch.step             <= word_queue[0].step;
        item_ch.expect_rise      <= word_queue[0].rise;
        item_ch.mean_interval    <= word_queue[0].avg;
        item_ch.elapsed_interval <= word_queue[0].elapsed;
        item_ch.falling_pending  <= word_queue[0].fpend;
        item_ch.rising_pending   <= word_queue[0].rpend;
        item_ch.samples          <= word_queue[0].samples;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long result stall while words keep coming
  initial begin
    hold_off = 1'b0;
    wait (press_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] filter, logic [CFG_DATA_W-1:0] fast,
                          logic [CFG_DATA_W-1:0] slow);
    write_reg(REG_FILT_LEN, filter);
    write_reg(REG_FAST_THRESHOLD, fast);
    write_reg(REG_SLOW_THRESHOLD, slow);
    if (filter[FILTER_W-1:0] == '0) begin
      shape_filter = 1;
    end else if (filter[FILTER_W-1:0] > MAX_FILTER) begin
      shape_filter = MAX_FILTER;
    end else begin
      shape_filter = filter[FILTER_W-1:0];
    end
    shape_fast = fast;
    shape_slow = slow;
  endtask

  task automatic drain();
    wait (word_queue.size() == 0 && !item_ch.valid && words_in_flight == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic void queue_commutation(logic [STEP_W-1:0] step, logic rise,
                                            logic [INTERVAL_W-1:0] avg);
    word_queue.push_back('{op: OP_COMMUTATE, step: step, rise: rise, avg: avg,
                           elapsed: 16'($urandom), fpend: 1'($urandom),
                           rpend: 1'($urandom), samples: 16'($urandom)});
    shape_level = rise;
  endfunction

  function automatic void queue_edge(logic fpend, logic rpend, logic [INTERVAL_W-1:0] avg,
                                     logic [INTERVAL_W-1:0] elapsed,
                                     logic [SAMPLE_W-1:0] samples);
    word_queue.push_back('{op: OP_EDGE, step: 3'($urandom), rise: 1'($urandom), avg: avg,
                           elapsed: elapsed, fpend: fpend, rpend: rpend,
                           samples: samples});
  endfunction

  function automatic logic [INTERVAL_W-1:0] pick_average();
    int base;
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1200));
      default: begin
        base = $urandom_range(1) ? shape_fast : shape_slow;
        base = base + int'($urandom_range(6)) - 3;
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        return 16'(base);
      end
    endcase
  endfunction

  task automatic queue_random(int count);
    int unsigned           pick;
    logic                  fp;
    logic                  rp;
    logic [INTERVAL_W-1:0] avg;
    logic [INTERVAL_W-1:0] half;
    logic [INTERVAL_W-1:0] elapsed;
    logic [SAMPLE_W-1:0]   win;
    logic [SAMPLE_W-1:0]   smp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 28) begin
        queue_commutation(($urandom_range(99) < 85) ? 3'($urandom_range(1, 6))
                                                    : 3'($urandom_range(1) * 7),
                          1'($urandom), pick_average());
      end else begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          fp = 1'b0;
          rp = 1'b0;
        end else if (pick < 20) begin
          fp = 1'b1;
          rp = 1'b1;
        end else begin
          fp = 1'($urandom);
          rp = !fp;
        end
        avg  = pick_average();
        half = avg >> 1;
        pick = $urandom_range(99);
        if (pick < 15) begin
          elapsed = half + 16'($urandom_range(1));
        end else if (pick < 65) begin
          elapsed = 16'($urandom_range(int'(half) + 1, 65535));
        end else begin
          elapsed = 16'($urandom_range(0, int'(half)));
        end
        // mostly a clean crossing, sometimes one bounce inside the window
        win  = 16'((32'd1 << shape_filter) - 32'd1);
        smp  = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 75) begin
          smp = (smp & ~win) | (shape_level ? 16'h0000 : win);
        end
        if (pick >= 55 && pick < 75) begin
          smp = smp ^ (16'd1 << $urandom_range(shape_filter - 1));
        end
        queue_edge(fp, rp, avg, elapsed, smp);
      end
    end
  endtask

  task automatic queue_directed();
    queue_commutation(3'd1, 1'b1, 16'd0);
    queue_edge(1'b0, 1'b1, 16'd100, 16'd51, 16'h0000);
    queue_edge(1'b0, 1'b1, 16'd100, 16'd50, 16'h0001);
    queue_edge(1'b0, 1'b1, 16'd100, 16'd50, 16'h0000);
    queue_edge(1'b1, 1'b1, 16'd100, 16'd60, 16'h0010);
    queue_edge(1'b0, 1'b0, 16'd100, 16'd60, 16'h0000);
    queue_commutation(3'd2, 1'b0, 16'd601);
    queue_commutation(3'd3, 1'b1, 16'd600);
    queue_commutation(3'd4, 1'b0, 16'd400);
    queue_commutation(3'd5, 1'b1, 16'd399);
    queue_commutation(3'd6, 1'b0, 16'hFFFF);
    queue_edge(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_edge(1'b1, 1'b0, 16'hFFFF, 16'd32767, 16'h0000);
    queue_edge(1'b1, 1'b0, 16'd0, 16'd0, 16'hFFE0);
    queue_edge(1'b1, 1'b0, 16'd0, 16'd1, 16'hFFDF);
    queue_edge(1'b1, 1'b0, 16'd0, 16'd1, 16'hFFEF);
    queue_commutation(3'd0, 1'b1, 16'd0);
    queue_commutation(3'd7, 1'b0, 16'd1000);
    queue_edge(1'b0, 1'b1, 16'd1000, 16'd1000, 16'h5555);
    queue_edge(1'b0, 1'b1, 16'd1000, 16'd1000, 16'hAAAA);
    queue_commutation(3'd1, 1'b1, 16'd500);
    queue_edge(1'b0, 1'b1, 16'd2, 16'd2, 16'hFFE0);
  endtask

  initial begin
    rst          = 1'b1;
    press_req    = 1'b0;
    src_idle_pct = 22;
    snk_idle_pct = 22;
    shape_filter = 5;
    shape_level  = 1'b0;
    shape_fast   = 16'd400;
    shape_slow   = 16'd600;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr  = '0;
    cfg_ch.data  = '0;
    item_ch.valid = 1'b0;
    {item_ch.op, item_ch.step, item_ch.expect_rise, item_ch.mean_interval,
     item_ch.elapsed_interval, item_ch.falling_pending, item_ch.rising_pending,
     item_ch.samples} = '0;
    result_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    drain();

    set_regs(16'd1, 16'd0, 16'hFFFF);
    queue_random(120);
    drain();

    // fast above slow: averages in between end in medium speed
    set_regs(16'd16, 16'hFFFF, 16'd0);
    queue_random(120);
    drain();

    set_regs(16'd0, 16'd400, 16'd600);
    write_reg(REG_UNUSED, 16'h1234);
    src_idle_pct = 0;
    press_req    = 1'b1;
    queue_random(130);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_regs(16'hFFFF, 16'd200, 16'd900);
    queue_random(130);
    drain();

    src_idle_pct = 22;
    snk_idle_pct = 22;
    set_regs(16'($urandom), 16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)));
    queue_random(125);
    drain();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== bemf_zero_cross_qualifier.f =====
rtl/bzcq_pkg.sv
rtl/bzcq_if.sv
rtl/bzcq_lane.sv
rtl/bzcq_merge.sv
rtl/bzcq_top_dummy_placeholder.sv
rtl/bemf_zero_cross_qualifier.sv
sim/bzcq_checker.sv
sim/tb_top.sv
